// ===== design/gceo_pkg.sv =====
`timescale 1ns / 1ps
package gceo_pkg;

	localparam int CELLS_DEF = 4096;
	localparam int SIG_DEPTH_DEF = 256;
	localparam int CELL_W = 12;
	localparam logic [31:0] PROC_NOISE = 32'd655;
	localparam logic [15:0] OBS_SCALE_AFTER = 16'd20;
	localparam int OCC_STEPS = 50;

	localparam logic [2:0] REG_ROBOT_X = 3'd0;
	localparam logic [2:0] REG_ROBOT_Y = 3'd1;
	localparam logic [2:0] REG_ROBOT_Z = 3'd2;
	localparam logic [2:0] REG_HIT_INC = 3'd3;
	localparam logic [2:0] REG_MISS_INC = 3'd4;
	localparam logic [2:0] REG_CLAMP = 3'd5;
	localparam logic [2:0] REG_BELIEF = 3'd6;
	localparam logic [2:0] REG_THRESH = 3'd7;

	// smallest q7.8 log-odds magnitude for occupancy 51..100
	function automatic logic [10:0] occ_step(input logic [5:0] i);
		logic [10:0] r;
		unique case (i)
			6'd0: r = 11'd6;     6'd1: r = 11'd16;   6'd2: r = 11'd26;
			6'd3: r = 11'd36;    6'd4: r = 11'd47;   6'd5: r = 11'd57;
			6'd6: r = 11'd67;    6'd7: r = 11'd78;   6'd8: r = 11'd88;
			6'd9: r = 11'd99;    6'd10: r = 11'd110; 6'd11: r = 11'd120;
			6'd12: r = 11'd131;  6'd13: r = 11'd142; 6'd14: r = 11'd153;
			6'd15: r = 11'd165;  6'd16: r = 11'd176; 6'd17: r = 11'd188;
			6'd18: r = 11'd200;  6'd19: r = 11'd211; 6'd20: r = 11'd224;
			6'd21: r = 11'd236;  6'd22: r = 11'd249; 6'd23: r = 11'd262;
			6'd24: r = 11'd275;  6'd25: r = 11'd289; 6'd26: r = 11'd303;
			6'd27: r = 11'd317;  6'd28: r = 11'd332; 6'd29: r = 11'd347;
			6'd30: r = 11'd363;  6'd31: r = 11'd380; 6'd32: r = 11'd397;
			6'd33: r = 11'd416;  6'd34: r = 11'd435; 6'd35: r = 11'd455;
			6'd36: r = 11'd476;  6'd37: r = 11'd499; 6'd38: r = 11'd523;
			6'd39: r = 11'd549;  6'd40: r = 11'd578; 6'd41: r = 11'd609;
			6'd42: r = 11'd644;  6'd43: r = 11'd683; 6'd44: r = 11'd729;
			6'd45: r = 11'd783;  6'd46: r = 11'd850; 6'd47: r = 11'd938;
			6'd48: r = 11'd1072; 6'd49: r = 11'd1356;
			default: r = 11'h7FF;
		endcase
		return r;
	endfunction

	typedef enum logic [3:0] {
		BK_IDLE, BK_RD, BK_RDW, BK_SQ, BK_SQRT, BK_PREP, BK_DIV, BK_MUL1, BK_MUL2,
		BK_MUL3, BK_OCC, BK_WR, BK_OUT, BK_CLR
	} bk_state_t;

	// one classified point between front and back
	typedef struct packed {
		logic [CELL_W-1:0] cidx;
		logic [63:0] sq;          // saturated squared distance
		logic signed [31:0] z;
		logic signed [15:0] inc;  // log-odds increment picked by hit flag
	} gceo_item_t;

endpackage

// ===== design/grid_cell_elevation_occupancy_update_unit.sv =====
`timescale 1ns / 1ps
// Per-cell elevation/variance/occupancy update. After reset the block clears the seen flag,
// log-odds and count of every cell before taking points. For a revisited cell the back end
// then runs a memory read, a 32-step square root of the squared distance, a 31-step gain
// divide, three multiply steps and a write-back; a first visit skips the divide and
// multiplies. The front end squares the three axis offsets in turn after its accept cycle
// and overlaps with the back end through a queue.
module grid_cell_elevation_occupancy_update_unit
	import gceo_pkg::*;
#(
	parameter int CELLS = CELLS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CELL_W-1:0] cell_index,
	input  logic [31:0]       point_x,
	input  logic [31:0]       point_y,
	input  logic [31:0]       point_z,
	input  logic              is_hit,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CELL_W-1:0] out_cell,
	output logic [31:0]       new_elevation,
	output logic [31:0]       new_variance,
	output logic [6:0]        occupancy_percent,
	output logic              ready_flag,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data
);
	logic [31:0] robot_x_q, robot_y_q, robot_z_q;
	logic [15:0] hit_q, miss_q, thresh_q;
	logic [14:0] clamp_q, belief_q;
	logic        fq_valid, fq_ready, bq_valid, bq_ready;
	gceo_item_t  fq_item, bq_item;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			robot_x_q <= '0;
			robot_y_q <= '0;
			robot_z_q <= '0;
			hit_q <= 16'd218;
			miss_q <= 16'hFF98;
			clamp_q <= 15'd5120;
			belief_q <= 15'd2048;
			thresh_q <= 16'd5;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROBOT_X: robot_x_q <= cfg_data;
				REG_ROBOT_Y: robot_y_q <= cfg_data;
				REG_ROBOT_Z: robot_z_q <= cfg_data;
				REG_HIT_INC: hit_q <= cfg_data[15:0];
				REG_MISS_INC: miss_q <= cfg_data[15:0];
				REG_CLAMP: clamp_q <= cfg_data[14:0];
				REG_BELIEF: belief_q <= cfg_data[14:0];
				REG_THRESH: thresh_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	gceo_front u_front (.clk, .arst_n, .in_valid, .in_ready, .cell_index, .point_x,
		.point_y, .point_z, .is_hit, .robot_x(robot_x_q), .robot_y(robot_y_q),
		.robot_z(robot_z_q), .hit_increment(hit_q), .miss_increment(miss_q),
		.fq_valid, .fq_ready, .fq_item);

	gceo_queue u_queue (.clk, .arst_n, .wr_valid(fq_valid), .wr_ready(fq_ready),
		.wr_item(fq_item), .rd_valid(bq_valid), .rd_ready(bq_ready), .rd_item(bq_item));

	gceo_back #(.CELLS(CELLS)) u_back (.clk, .arst_n, .q_valid(bq_valid),
		.q_ready(bq_ready), .q_item(bq_item), .clamp_limit(clamp_q),
		.belief_limit(belief_q), .observe_threshold(thresh_q), .out_valid, .out_ready,
		.out_cell, .new_elevation, .new_variance, .occupancy_percent, .ready_flag);
endmodule

// ===== design/gceo_ram.sv =====
`timescale 1ns / 1ps
module gceo_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== design/gceo_front.sv =====
`timescale 1ns / 1ps
module gceo_front
	import gceo_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CELL_W-1:0] cell_index,
	input  logic [31:0]       point_x,
	input  logic [31:0]       point_y,
	input  logic [31:0]       point_z,
	input  logic              is_hit,
	input  logic [31:0]       robot_x,
	input  logic [31:0]       robot_y,
	input  logic [31:0]       robot_z,
	input  logic [15:0]       hit_increment,
	input  logic [15:0]       miss_increment,
	output logic              fq_valid,
	input  logic              fq_ready,
	output gceo_item_t        fq_item
);
	// staged: capture, then one axis squared per cycle
	logic               busy_q, done_q;
	logic [1:0]         axis_q;
	logic [31:0]        px_q, py_q;
	logic [32:0]        mag_q;
	logic [64:0]        acc_q;
	gceo_item_t         it_q;
	logic signed [32:0] d;
	logic [32:0]        m;
	logic [65:0]        sum;

	always_comb begin
		unique case (axis_q)
			2'd0: d = $signed({px_q[31], px_q}) - $signed({robot_x[31], robot_x});
			2'd1: d = $signed({py_q[31], py_q}) - $signed({robot_y[31], robot_y});
			default: d = $signed({it_q.z[31], it_q.z}) - $signed({robot_z[31], robot_z});
		endcase
		m = d[32] ? 33'(-d) : 33'(d);
		sum = {1'b0, acc_q} + {1'b0, 65'(mag_q) * 65'(mag_q)};
	end

	assign in_ready = !busy_q;
	assign fq_valid = done_q;
	assign fq_item = it_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			axis_q <= 2'd0;
		end else if (!busy_q) begin
			if (in_valid) begin
				busy_q <= 1'b1;
				axis_q <= 2'd0;
			end
		end else if (done_q) begin
			if (fq_ready) begin
				busy_q <= 1'b0;
				done_q <= 1'b0;
			end
		end else if (axis_q == 2'd3) begin
			done_q <= 1'b1;
		end else begin
			axis_q <= axis_q + 2'd1;
		end
	end

	// square of the previous axis accumulates while the next difference forms
	always_ff @(posedge clk) begin
		if (!busy_q && in_valid) begin
			px_q <= point_x;
			py_q <= point_y;
			it_q.cidx <= cell_index;
			it_q.z <= point_z;
			it_q.inc <= is_hit ? hit_increment : miss_increment;
			acc_q <= '0;
			mag_q <= '0;
		end else if (busy_q && !done_q) begin
			mag_q <= m;
			acc_q <= (sum[65:64] != 2'b0) ? {1'b0, {64{1'b1}}} : sum[64:0];
			if (axis_q == 2'd3) begin
				it_q.sq <= (sum[65:64] != 2'b0) ? {64{1'b1}} : sum[63:0];
			end
		end
	end
endmodule

// ===== design/gceo_queue.sv =====
`timescale 1ns / 1ps
module gceo_queue
	import gceo_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_valid,
	output logic       wr_ready,
	input  gceo_item_t wr_item,
	output logic       rd_valid,
	input  logic       rd_ready,
	output gceo_item_t rd_item
);
	// two-entry queue
	gceo_item_t ent_q [2];
	logic [1:0] cnt_q;
	logic       wp_q, rp_q;
	logic       push, pop;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_item = ent_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= wr_item;
		end
	end
endmodule

// ===== design/gceo_back.sv =====
`timescale 1ns / 1ps
module gceo_back
	import gceo_pkg::*;
#(
	parameter int CELLS = CELLS_DEF,
	localparam int AW = $clog2(CELLS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_ready,
	input  gceo_item_t        q_item,
	input  logic [14:0]       clamp_limit,
	input  logic [14:0]       belief_limit,
	input  logic [15:0]       observe_threshold,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CELL_W-1:0] out_cell,
	output logic [31:0]       new_elevation,
	output logic [31:0]       new_variance,
	output logic [6:0]        occupancy_percent,
	output logic              ready_flag
);
	bk_state_t st_q, st_d;

	gceo_item_t  it_q;
	logic [AW-1:0] addr_q;
	logic [AW:0]   clr_q;
	logic [5:0]  cnt6_q;
	// sqrt
	logic [63:0] rem_q;
	logic [31:0] root_q;
	logic [65:0] rtrial;
	// kalman
	logic [32:0] p_q;
	logic [35:0] den_q;
	logic [30:0] num_q;
	logic [30:0] k_q;
	logic [36:0] drem_q;
	logic signed [32:0] diff_q;
	logic [63:0] prod_q;
	logic [63:0] prod2_q;
	logic [31:0] elev_q, var_q;
	logic [15:0] lo_q, cntn_q;
	logic [6:0]  occ_q;
	logic [32:0] psat;
	logic [36:0] dshift;
	logic [37:0] dtrial;
	// memories
	logic        mwe;
	logic [AW-1:0] mwa;
	logic [31:0] elev_rd, var_rd;
	logic [15:0] lo_rd, cnt_rd;
	logic        seen_rd;
	logic [15:0] lo_wd, cnt_wd;
	logic        seen_wd;
	logic signed [16:0] lsum;
	logic [15:0] lmag;
	logic [6:0]  occ_pos;
	logic [31:0] adj;

	gceo_ram #(.WIDTH(32), .DEPTH(CELLS)) u_elev (.clk, .we(mwe && st_q == BK_WR),
		.waddr(mwa), .wdata(elev_q), .raddr(addr_q), .rdata(elev_rd));
	gceo_ram #(.WIDTH(32), .DEPTH(CELLS)) u_var (.clk, .we(mwe && st_q == BK_WR),
		.waddr(mwa), .wdata(var_q), .raddr(addr_q), .rdata(var_rd));
	gceo_ram #(.WIDTH(33), .DEPTH(CELLS)) u_aux (.clk, .we(mwe),
		.waddr(mwa), .wdata({seen_wd, lo_wd, cnt_wd}), .raddr(addr_q),
		.rdata({seen_rd, lo_rd, cnt_rd}));

	// clearing pass writes zero into seen, log-odds and count
	assign mwe = (st_q == BK_WR) || (st_q == BK_CLR);
	assign mwa = (st_q == BK_CLR) ? clr_q[AW-1:0] : addr_q;
	assign seen_wd = st_q == BK_WR;
	assign lo_wd = (st_q == BK_WR) ? lo_q : 16'd0;
	assign cnt_wd = (st_q == BK_WR) ? cntn_q : 16'd0;

	assign rtrial = {2'b0, rem_q} - {2'b0, root_q, 2'b01} * 66'(1);
	// prior variance plus process noise, saturated to 32 bits
	assign psat = ({1'b0, var_rd} + 33'(PROC_NOISE) > 33'hFFFFFFFF) ? 33'hFFFFFFFF :
		{1'b0, var_rd} + 33'(PROC_NOISE);
	assign dshift = {drem_q[35:0], num_q[30]};
	assign dtrial = {1'b0, dshift} - {2'b0, den_q};
	assign lsum = $signed({lo_rd[15], lo_rd}) + $signed({it_q.inc[15], it_q.inc});
	assign lmag = lo_q[15] ? 16'(-lo_q) : lo_q;
	assign adj = 32'((prod_q + 64'(1 << 29)) >> 30);

	always_comb begin
		occ_pos = 7'd50;
		for (int i = 0; i < OCC_STEPS; i++) begin
			if ({5'd0, occ_step(6'(i))} <= lmag) begin
				occ_pos = 7'(51 + i);
			end
		end
	end

	assign q_ready = st_q == BK_IDLE;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			BK_CLR:  if (clr_q[AW]) st_d = BK_IDLE;
			BK_IDLE: if (q_valid) st_d = BK_RD;
			BK_RD:   st_d = BK_RDW;
			BK_RDW:  st_d = BK_SQ;
			BK_SQ:   st_d = BK_SQRT;
			BK_SQRT: if (cnt6_q == 6'd31) st_d = BK_PREP;
			BK_PREP: st_d = seen_rd ? BK_DIV : BK_OCC;
			BK_DIV:  if (cnt6_q == 6'd30) st_d = BK_MUL1;
			BK_MUL1: st_d = BK_MUL2;
			BK_MUL2: st_d = BK_MUL3;
			BK_MUL3: st_d = BK_OCC;
			BK_OCC:  st_d = BK_WR;
			BK_WR:   st_d = BK_OUT;
			BK_OUT:  if (out_ready) st_d = BK_IDLE;
			default: st_d = BK_IDLE;
		endcase
	end

	assign out_valid = st_q == BK_OUT;
	assign out_cell = CELL_W'(addr_q);
	assign new_elevation = elev_q;
	assign new_variance = var_q;
	assign occupancy_percent = occ_q;
	assign ready_flag = cntn_q >= observe_threshold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_CLR;
			clr_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == BK_CLR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			BK_IDLE: begin
				it_q <= q_item;
				addr_q <= AW'(q_item.cidx);
			end
			BK_SQ: begin
				rem_q <= it_q.sq;
				root_q <= '0;
				cnt6_q <= '0;
			end
			BK_SQRT: begin
				// restoring square root, two bits per step
				if (rtrial[65] == 1'b0 &&
						{2'b0, rem_q} >= ({34'd0, root_q, 2'b01} << (62 - 2 * cnt6_q))) begin
					rem_q <= rem_q - 64'(({34'd0, root_q, 2'b01}) << (62 - 2 * cnt6_q));
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					root_q <= {root_q[30:0], 1'b0};
				end
				cnt6_q <= cnt6_q + 6'd1;
			end
			BK_PREP: begin
				cntn_q <= (cnt_rd == 16'hFFFF) ? cnt_rd : cnt_rd + 16'd1;
				lo_q <= ($signed(lsum) < -$signed({2'b0, clamp_limit})) ?
					16'(-$signed({2'b0, clamp_limit})) :
					($signed(lsum) > $signed({2'b0, clamp_limit})) ?
					{1'b0, clamp_limit} : lsum[15:0];
				elev_q <= seen_rd ? elev_rd : it_q.z;
				var_q <= seen_rd ? var_rd : root_q;
				p_q <= psat;
				den_q <= 36'(psat) +
					((cnt_rd > OBS_SCALE_AFTER) ? 36'(root_q) * 36'd10 : 36'(root_q));
				// gain is below 2^31, so p << 30 divided by p + r starts from p >> 1
				drem_q <= 37'(psat[32:1]);
				num_q <= {psat[0], 30'd0};
				k_q <= '0;
				cnt6_q <= '0;
				diff_q <= $signed({it_q.z[31], it_q.z}) - $signed({elev_rd[31], elev_rd});
			end
			BK_DIV: begin
				// one quotient bit per cycle, 31 bits of p*2^30/(p+r)
				if (!dtrial[37]) begin
					drem_q <= dtrial[36:0];
					k_q <= {k_q[29:0], 1'b1};
				end else begin
					drem_q <= dshift;
					k_q <= {k_q[29:0], 1'b0};
				end
				num_q <= {num_q[29:0], 1'b0};
				cnt6_q <= cnt6_q + 6'd1;
			end
			BK_MUL1: begin
				prod_q <= 64'(k_q) * 64'(diff_q[32] ? 33'(-diff_q) : 33'(diff_q));
			end
			BK_MUL2: begin
				elev_q <= diff_q[32] ? elev_q - adj : elev_q + adj;
				prod2_q <= 64'((31'd1 << 30) - k_q) * 64'(p_q);
			end
			BK_MUL3: begin
				var_q <= 32'((prod2_q + 64'(1 << 29)) >> 30);
			end
			BK_OCC: begin
				if ($signed(lo_q) < -$signed({1'b0, belief_limit})) begin
					occ_q <= 7'd0;
				end else if ($signed(lo_q) > $signed({1'b0, belief_limit})) begin
					occ_q <= 7'd100;
				end else begin
					occ_q <= lo_q[15] ? 7'd100 - occ_pos : occ_pos;
				end
			end
			default: begin
			end
		endcase
	end
endmodule
